// ----- src/batt_uv_pkg.sv -----
// ----------------------------------------------------------------------------
// batt_uv_pkg: battery undervoltage shutdown shared definitions
// Payload structs, register indexes and the timing constants of the supervisor.
// ----------------------------------------------------------------------------
package batt_uv_pkg;

  // Timing, in control ticks
  localparam int SHUTDOWN_TICKS    = 10000;
  localparam int WARN_PERIOD_TICKS = 1000;
  localparam int DISCHARGE_TICKS   = 800;

  localparam int WARN_PHASE      = WARN_PERIOD_TICKS / 10;
  localparam int SERVO_OFF_TICKS = SHUTDOWN_TICKS / 2;
  localparam int CONFIRM_COUNT   = 5;
  // seconds_left on a warning tick is SECS_BASE minus whole periods counted
  localparam int SECS_BASE       = (SHUTDOWN_TICKS - WARN_PHASE) / WARN_PERIOD_TICKS;

  localparam int VOLT_W  = 12;
  localparam int SECS_W  = 4;
  localparam int CNT_W   = 15;
  localparam int PHASE_W = $clog2(WARN_PERIOD_TICKS);
  localparam int QUOT_W  = $clog2(SHUTDOWN_TICKS / WARN_PERIOD_TICKS + 2);
  localparam int CFG_IDX_W = 1;

  localparam logic [SECS_W-1:0] SECS_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_VOLTAGE      = 1'b0,
    REG_USB_FLOOR_VOLTAGE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [VOLT_W-1:0] idle_voltage;
    logic [VOLT_W-1:0] usb_floor_voltage;
  } cfg_t;

  typedef struct packed {
    logic [VOLT_W-1:0] battery_sample;
    logic              halt_request;
    logic              servos_on;
  } in_item_t;

  typedef struct packed {
    logic              power_enable;
    logic              power_restored;
    logic              power_cut;
    logic              cut_by_halt;
    logic              warning;
    logic [SECS_W-1:0] seconds_left;
    logic              mission_stop;
    logic              servo_disable;
  } out_item_t;

endpackage

// ----- src/batt_uv_core.sv -----
// ----------------------------------------------------------------------------
// batt_uv_core: supervisor state and per-tick update
// Holds the off flag, sticky halt and tick counter; evaluates one tick when
// step is high and presents that tick's result combinationally.
// ----------------------------------------------------------------------------
module batt_uv_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  batt_uv_pkg::cfg_t     cfg,
  input  batt_uv_pkg::in_item_t item,
  output batt_uv_pkg::out_item_t result
);

  localparam logic signed [batt_uv_pkg::CNT_W-1:0] SHUTDOWN_CNT =
    batt_uv_pkg::CNT_W'(batt_uv_pkg::SHUTDOWN_TICKS);
  localparam logic signed [batt_uv_pkg::CNT_W-1:0] SERVO_OFF_CNT =
    batt_uv_pkg::CNT_W'(batt_uv_pkg::SERVO_OFF_TICKS);
  localparam logic signed [batt_uv_pkg::CNT_W-1:0] DISCHARGE_CNT =
    -(batt_uv_pkg::CNT_W'(batt_uv_pkg::DISCHARGE_TICKS));
  localparam logic signed [batt_uv_pkg::CNT_W-1:0] CONFIRM_CNT =
    batt_uv_pkg::CNT_W'(batt_uv_pkg::CONFIRM_COUNT);
  localparam logic [batt_uv_pkg::PHASE_W-1:0] PHASE_LAST =
    batt_uv_pkg::PHASE_W'(batt_uv_pkg::WARN_PERIOD_TICKS - 1);
  localparam logic [batt_uv_pkg::PHASE_W-1:0] PHASE_WARN =
    batt_uv_pkg::PHASE_W'(batt_uv_pkg::WARN_PHASE);
  localparam logic [batt_uv_pkg::QUOT_W-1:0] SECS_BASE_Q =
    batt_uv_pkg::QUOT_W'(batt_uv_pkg::SECS_BASE);

  logic                                   supply_off_r, supply_off_nxt;
  logic                                   halt_pending_r, halt_pending_nxt;
  logic signed [batt_uv_pkg::CNT_W-1:0]   count_r, count_nxt;
  // count mod period and count / period, tracked alongside while powered
  logic [batt_uv_pkg::PHASE_W-1:0]        phase_r, phase_nxt;
  logic [batt_uv_pkg::QUOT_W-1:0]         quot_r, quot_nxt;

  logic                                   halt;
  logic                                   low_sample;
  logic signed [batt_uv_pkg::CNT_W-1:0]   count_inc;
  logic [batt_uv_pkg::QUOT_W-1:0]         secs_diff;

  always_comb begin
    halt       = halt_pending_r | item.halt_request;
    low_sample = (item.battery_sample < cfg.idle_voltage) &&
                 (item.battery_sample > cfg.usb_floor_voltage);
    count_inc  = count_r + batt_uv_pkg::CNT_W'(1);
    secs_diff  = SECS_BASE_Q - quot_r;

    supply_off_nxt   = supply_off_r;
    halt_pending_nxt = halt;
    count_nxt        = count_r;
    phase_nxt        = phase_r;
    quot_nxt         = quot_r;
    result           = '0;

    if (supply_off_r) begin
      if (count_r < 0) begin
        count_nxt = (count_inc == '0) ? CONFIRM_CNT : count_inc;
      end else if (item.battery_sample >= cfg.idle_voltage) begin
        if (count_r == '0) begin
          supply_off_nxt        = 1'b0;
          halt_pending_nxt      = 1'b0;
          result.power_restored = 1'b1;
        end else begin
          count_nxt = count_r - batt_uv_pkg::CNT_W'(1);
        end
      end
    end else if (low_sample || halt) begin
      count_nxt = count_inc;
      if (phase_r == PHASE_LAST) begin
        phase_nxt = '0;
        quot_nxt  = quot_r + batt_uv_pkg::QUOT_W'(1);
      end else begin
        phase_nxt = phase_r + batt_uv_pkg::PHASE_W'(1);
      end
      // phase_nxt == warn phase means quot_r whole periods already counted
      if (phase_nxt == PHASE_WARN && count_inc < SHUTDOWN_CNT) begin
        result.warning      = 1'b1;
        result.mission_stop = 1'b1;
        result.seconds_left = (secs_diff > batt_uv_pkg::QUOT_W'(batt_uv_pkg::SECS_MAX)) ?
                              batt_uv_pkg::SECS_MAX : secs_diff[batt_uv_pkg::SECS_W-1:0];
        if (count_inc >= SERVO_OFF_CNT && item.servos_on) begin
          result.servo_disable = 1'b1;
        end
      end
      if (count_inc > SHUTDOWN_CNT || halt) begin
        if (item.servos_on) begin
          result.servo_disable = 1'b1;
        end
        result.power_cut   = 1'b1;
        result.cut_by_halt = halt;
        supply_off_nxt     = 1'b1;
        count_nxt          = DISCHARGE_CNT;
        phase_nxt          = '0;
        quot_nxt           = '0;
      end
    end else begin
      count_nxt = '0;
      phase_nxt = '0;
      quot_nxt  = '0;
    end

    result.power_enable = !supply_off_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_off_r   <= 1'b0;
      halt_pending_r <= 1'b0;
      count_r        <= '0;
      phase_r        <= '0;
      quot_r         <= '0;
    end else if (step) begin
      supply_off_r   <= supply_off_nxt;
      halt_pending_r <= halt_pending_nxt;
      count_r        <= count_nxt;
      phase_r        <= phase_nxt;
      quot_r         <= quot_nxt;
    end
  end

endmodule

// ----- src/battery_undervoltage_shutdown.sv -----
// ----------------------------------------------------------------------------
// battery_undervoltage_shutdown: per-tick battery supervisor
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   in_data  (batt_uv_pkg::in_item_t)
//   out_      output     out_valid / out_ready out_data (batt_uv_pkg::out_item_t)
//   cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ready stays high; each input is
// registered twice, in the input register and then in the result register.
// The state update sits between those two registers and runs once per tick.
// rst_n is synchronous: both stages empty, powered, no halt, count zero,
// registers at their defaults. A stalled out_ready holds the result and backs
// up into the input register before in_ready drops.
// ----------------------------------------------------------------------------
module battery_undervoltage_shutdown (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  batt_uv_pkg::in_item_t                 in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output batt_uv_pkg::out_item_t                out_data,
  input  logic                                  cfg_we,
  input  logic [batt_uv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [batt_uv_pkg::VOLT_W-1:0]        cfg_wdata
);

  batt_uv_pkg::cfg_t      cfg_r;
  batt_uv_pkg::in_item_t  item_r;
  logic                   item_valid_r;
  batt_uv_pkg::out_item_t res_r;
  logic                   res_valid_r;
  batt_uv_pkg::out_item_t result;
  logic                   advance;

  // stage 1 moves on when the result register is free or being drained
  assign advance  = !res_valid_r || out_ready;
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_voltage      <= batt_uv_pkg::VOLT_W'(2048);
      cfg_r.usb_floor_voltage <= batt_uv_pkg::VOLT_W'(1034);
    end else if (cfg_we) begin
      case (cfg_index)
        batt_uv_pkg::REG_IDLE_VOLTAGE:      cfg_r.idle_voltage      <= cfg_wdata;
        batt_uv_pkg::REG_USB_FLOOR_VOLTAGE: cfg_r.usb_floor_voltage <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (advance) begin
        res_valid_r <= item_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (advance && item_valid_r) begin
      res_r <= result;
    end
  end

  batt_uv_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance && item_valid_r),
    .cfg    (cfg_r),
    .item   (item_r),
    .result (result)
  );

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

// ----- src/batt_uv_checker.sv -----
// ----------------------------------------------------------------------------
// batt_uv_checker: port-level checks for the battery supervisor
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module batt_uv_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input batt_uv_pkg::out_item_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a cut leaves power off, never together with a restore
  a_cut_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.power_cut |->
      !out_data.power_enable && !out_data.power_restored)
    else $error("power cut inconsistent with power level");

  a_halt_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cut_by_halt |-> out_data.power_cut)
    else $error("cut_by_halt without power_cut");

  a_warn_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.warning == out_data.mission_stop) &&
      (out_data.warning || out_data.seconds_left == '0))
    else $error("warning fields inconsistent");

endmodule

bind battery_undervoltage_shutdown batt_uv_checker u_batt_uv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/sv/battery_undervoltage_shutdown_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_undervoltage_shutdown_test: self-checking bench for the supervisor
// A directed table opens the run and ends in a halt shutdown, which is then
// recovered. Random phases follow, each with its own thresholds: noise and, with a low
// band open, low runs that may reach the first warning. Each result is checked field by
// field, pinned rows against their fixed expectation and the rest against a cycle-free
// tick model. The sender idles in bursts and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module battery_undervoltage_shutdown_test;

  localparam int CYCLE_LIMIT = 2500000;

  localparam batt_uv_pkg::out_item_t ON_QUIET  = '{power_enable: 1'b1, default: '0};
  localparam batt_uv_pkg::out_item_t OFF_QUIET = '0;
  localparam batt_uv_pkg::out_item_t HALT_CUT  = '{power_cut: 1'b1, cut_by_halt: 1'b1,
                                                   servo_disable: 1'b1, default: '0};

  typedef enum {LOW_BAND, GOOD_LEVEL, BELOW_IDLE, ANY_LEVEL} level_t;

  typedef struct {
    batt_uv_pkg::in_item_t  stim;
    bit                     pinned;
    batt_uv_pkg::out_item_t want;
  } step_t;

  typedef struct {
    logic [batt_uv_pkg::VOLT_W-1:0] idle;
    logic [batt_uv_pkg::VOLT_W-1:0] usb_floor;
  } setting_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  batt_uv_pkg::in_item_t                in_data = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  batt_uv_pkg::out_item_t               out_data;
  logic                                 cfg_we = 1'b0;
  logic [batt_uv_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [batt_uv_pkg::VOLT_W-1:0]       cfg_wdata = '0;

  // Fixed expectation travels with the transaction for pinned table rows
  logic                                 pin_on = 1'b0;
  batt_uv_pkg::out_item_t               pin_res = '0;

  // Tick model state and its copy of the thresholds
  logic                                 power_down;
  logic                                 halt_latched;
  logic signed [batt_uv_pkg::CNT_W-1:0] low_ticks;
  logic [batt_uv_pkg::VOLT_W-1:0]       idle_level;
  logic [batt_uv_pkg::VOLT_W-1:0]       usb_level;
  batt_uv_pkg::out_item_t               due_status[$];

  // Thresholds the stimulus aims at
  logic [batt_uv_pkg::VOLT_W-1:0]       lvl_idle = 12'd2048;
  logic [batt_uv_pkg::VOLT_W-1:0]       lvl_floor = 12'd1034;

  int                                   fail_count = 0;
  int                                   burst_left = 0;
  logic [15:0]                          ready_pattern = '1;
  int                                   ready_hold = 0;

  battery_undervoltage_shutdown i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic batt_uv_pkg::out_item_t supervise_tick(batt_uv_pkg::in_item_t it);
    batt_uv_pkg::out_item_t r;
    int cnt;
    int secs;
    r = '0;
    cnt = low_ticks;
    if (it.halt_request) halt_latched = 1'b1;
    if (power_down) begin
      if (cnt < 0) begin
        cnt++;
        if (cnt == 0) cnt = batt_uv_pkg::CONFIRM_COUNT;
      end else if (it.battery_sample >= idle_level) begin
        if (cnt == 0) begin
          power_down = 1'b0;
          halt_latched = 1'b0;
          r.power_restored = 1'b1;
        end else begin
          cnt--;
        end
      end
    end else if ((it.battery_sample < idle_level && it.battery_sample > usb_level) ||
                 halt_latched) begin
      cnt++;
      if (cnt % batt_uv_pkg::WARN_PERIOD_TICKS == batt_uv_pkg::WARN_PHASE &&
          cnt < batt_uv_pkg::SHUTDOWN_TICKS) begin
        secs = (batt_uv_pkg::SHUTDOWN_TICKS - cnt) / batt_uv_pkg::WARN_PERIOD_TICKS;
        if (secs > 15) secs = 15;
        if (secs < 0) secs = 0;
        r.warning = 1'b1;
        r.seconds_left = secs[batt_uv_pkg::SECS_W-1:0];
        r.mission_stop = 1'b1;
        if (cnt >= batt_uv_pkg::SERVO_OFF_TICKS && it.servos_on) r.servo_disable = 1'b1;
      end
      if (cnt > batt_uv_pkg::SHUTDOWN_TICKS || halt_latched) begin
        if (it.servos_on) r.servo_disable = 1'b1;
        r.power_cut = 1'b1;
        r.cut_by_halt = halt_latched;
        power_down = 1'b1;
        cnt = -batt_uv_pkg::DISCHARGE_TICKS;
      end
    end else begin
      cnt = 0;
    end
    low_ticks = batt_uv_pkg::CNT_W'(cnt);
    r.power_enable = !power_down;
    return r;
  endfunction

  task automatic check_field(string field, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    batt_uv_pkg::out_item_t pred;
    batt_uv_pkg::out_item_t want;
    if (!rst_n) begin
      power_down = 1'b0;
      halt_latched = 1'b0;
      low_ticks = '0;
      idle_level = 12'd2048;
      usb_level = 12'd1034;
      due_status.delete();
    end else begin
      if (cfg_we) begin
        case (batt_uv_pkg::cfg_reg_t'(cfg_index))
          batt_uv_pkg::REG_IDLE_VOLTAGE:      idle_level = cfg_wdata;
          batt_uv_pkg::REG_USB_FLOOR_VOLTAGE: usb_level = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pred = supervise_tick(in_data);
        if (pin_on) pred = pin_res;
        due_status.push_back(pred);
      end
      if (out_valid && out_ready) begin
        if (due_status.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = due_status.pop_front();
          check_field("power_enable", want.power_enable, out_data.power_enable);
          check_field("power_restored", want.power_restored, out_data.power_restored);
          check_field("power_cut", want.power_cut, out_data.power_cut);
          check_field("cut_by_halt", want.cut_by_halt, out_data.cut_by_halt);
          check_field("warning", want.warning, out_data.warning);
          check_field("seconds_left", want.seconds_left, out_data.seconds_left);
          check_field("mission_stop", want.mission_stop, out_data.mission_stop);
          check_field("servo_disable", want.servo_disable, out_data.servo_disable);
        end
      end
    end
  end

  // Receiver: rotating stall mask, refreshed now and then; all-ones gives
  // stretches without back-pressure.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_pattern = ($urandom_range(3, 0) == 0) ? 16'hffff : 16'($urandom);
      ready_hold = 64;
    end
    out_ready <= ready_pattern[0] | ready_pattern[1];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    ready_hold--;
  end

  function automatic bit band_open();
    return int'(lvl_idle) > int'(lvl_floor) + 1;
  endfunction

  function automatic batt_uv_pkg::in_item_t make_tick(level_t lvl, bit halt);
    batt_uv_pkg::in_item_t it;
    it.halt_request = halt;
    it.servos_on = 1'($urandom_range(1, 0));
    case (lvl)
      LOW_BAND:
        it.battery_sample = band_open() ?
            12'($urandom_range(lvl_idle - 1, lvl_floor + 1)) : 12'($urandom_range(4095, 0));
      GOOD_LEVEL:
        it.battery_sample = 12'($urandom_range(4095, lvl_idle));
      BELOW_IDLE:
        it.battery_sample = 12'($urandom_range(lvl_idle == 0 ? 0 : lvl_idle - 1, 0));
      default:
        it.battery_sample = 12'($urandom_range(4095, 0));
    endcase
    return it;
  endfunction

  // Send one tick; returns at the edge where it was accepted
  task automatic push_tick(input batt_uv_pkg::in_item_t it, input bit pin,
                           input batt_uv_pkg::out_item_t want);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(15, 0) == 0) begin
        burst_left = $urandom_range(400, 200);
        gap = 0;
      end else begin
        burst_left = $urandom_range(24, 1);
        gap = $urandom_range(1, 0) ? $urandom_range(3, 1) : 0;
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data <= it;
    pin_on <= pin;
    pin_res <= want;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Discharge wait with stray halts, then mostly good samples to confirm
  task automatic recover_supply();
    repeat (batt_uv_pkg::DISCHARGE_TICKS)
      push_tick(make_tick(ANY_LEVEL, $urandom_range(19, 0) == 0), 1'b0, '0);
    repeat (20)
      push_tick(make_tick($urandom_range(4, 0) ? GOOD_LEVEL : BELOW_IDLE, 1'b0), 1'b0, '0);
  endtask

  task automatic drain_results(int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_status.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL battery_undervoltage_shutdown");
    $finish;
  end

  initial begin : stimulus
    step_t    steps [13];
    setting_t settings [8];
    int       n;

    // After reset, default thresholds 2048 / 1034
    steps = '{
      '{'{12'd0,    1'b0, 1'b0}, 1'b1, ON_QUIET},   // USB level
      '{'{12'd4095, 1'b0, 1'b1}, 1'b1, ON_QUIET},
      '{'{12'd1034, 1'b0, 1'b1}, 1'b1, ON_QUIET},   // exactly at floor
      '{'{12'd1035, 1'b0, 1'b0}, 1'b1, ON_QUIET},   // just above floor: low
      '{'{12'd2047, 1'b0, 1'b1}, 1'b1, ON_QUIET},
      '{'{12'd2048, 1'b0, 1'b0}, 1'b1, ON_QUIET},   // at idle: clears count
      '{'{12'd1500, 1'b0, 1'b1}, 1'b1, ON_QUIET},
      '{'{12'd2000, 1'b1, 1'b1}, 1'b1, HALT_CUT},   // halt acts same tick
      '{'{12'd4095, 1'b0, 1'b0}, 1'b1, OFF_QUIET},
      '{'{12'd0,    1'b1, 1'b1}, 1'b1, OFF_QUIET},  // halt while off
      '{'{12'd2730, 1'b1, 1'b0}, 1'b0, OFF_QUIET},
      '{'{12'd1365, 1'b0, 1'b1}, 1'b0, OFF_QUIET},
      '{'{12'd4095, 1'b1, 1'b1}, 1'b0, OFF_QUIET}
    };

    settings = '{
      '{12'd2048, 12'd1034},
      '{12'd4095, 12'd0},
      '{12'd0,    12'd4095},
      '{12'd0,    12'd0},
      '{12'd4095, 12'd4095},
      '{12'd0,    12'd0},
      '{12'd2,    12'd0},
      '{12'd3000, 12'd2990}
    };
    settings[5] = '{12'($urandom), 12'($urandom)};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) push_tick(steps[i].stim, steps[i].pinned, steps[i].want);

    // the table ends with power cut by a halt
    recover_supply();

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain_results(2);
        cfg_we <= 1'b1;
        cfg_index <= batt_uv_pkg::REG_IDLE_VOLTAGE;
        cfg_wdata <= settings[p].idle;
        @(posedge clk);
        cfg_index <= batt_uv_pkg::REG_USB_FLOOR_VOLTAGE;
        cfg_wdata <= settings[p].usb_floor;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      lvl_idle = settings[p].idle;
      lvl_floor = settings[p].usb_floor;

      repeat (25) push_tick(make_tick(ANY_LEVEL, 1'b0), 1'b0, '0);

      // low run that may reach the first warning
      if (band_open()) begin
        n = $urandom_range(130, 95);
        repeat (n)
          push_tick(make_tick($urandom_range(99, 0) == 0 ? ANY_LEVEL : LOW_BAND, 1'b0),
                    1'b0, '0);
        push_tick(make_tick(GOOD_LEVEL, 1'b0), 1'b0, '0);
      end
    end

    drain_results(4);
    if (fail_count == 0) begin
      $display("PASS battery_undervoltage_shutdown");
    end else begin
      $display("FAIL battery_undervoltage_shutdown");
    end
    $finish;
  end

endmodule
